### rtl/xpfec_pkg.sv
// Shared constants, opcodes and status codes of the XOR parity packet FEC unit.
package xpfec_pkg;

  // Store geometry.
  localparam int MAX_BYTES = 2048;
  localparam int ADDR_W    = $clog2(MAX_BYTES);
  localparam int OFF_W     = 11;
  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 12;

  // Each store entry carries an epoch tag beside its byte.
  localparam int EPOCH_W   = 8;
  localparam int ENTRY_W   = EPOCH_W + BYTE_W;

  // Stream payload widths.
  localparam int S_DATA_W  = 24;
  localparam int S_USER_W  = 2;
  localparam int M_DATA_W  = 24;
  localparam int M_USER_W  = 3;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 1'd1;

  // Opcodes.
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_ACCUM  = 2'd1;
  localparam logic [1:0] OP_ABSENT = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  // Read status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_NOT_REC = 2'd2;

  // Absent-packet counter.
  localparam logic [1:0] ABSENT_SAT = 2'd2;
  localparam logic [1:0] ABSENT_ONE = 2'd1;

endpackage

### rtl/xpfec_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module xpfec_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port; a read of the same address in the same cycle returns the old word.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### rtl/xor_parity_packet_fec_unit.sv
// Top level of the XOR parity packet FEC unit: parity store pipeline and stream ports.
//
// Usage: each transaction on the s_axis channel is one operation (clear group,
// accumulate byte, mark source packet absent, read byte). Every operation
// returns exactly one result transaction on m_axis, in order, carrying the
// parity or recovered byte, the group length, a read status and an offset
// error flag. The cfg channel writes the mode and byte limit registers; it
// is always ready and is meant to be used only while the unit is idle.
// An accepted operation is registered in stage two and then in the output
// register; one operation is taken every cycle unless a sweep or a stall
// holds the flow. The parity store is a RAM with one read and one write port,
// read in the first stage and written back in the second, with a forwarding
// path for back-to-back bytes at the same offset. Clearing bumps an epoch tag
// kept in each store word. After reset, and after every 255th clear when the
// epoch wraps, a sweep retags all 2048 store entries and s_axis_tready stays
// low. When the receiver stalls, the result waits in the output register and
// the pipeline holds; s_axis_tready drops once the second stage is occupied.
module xor_parity_packet_fec_unit
  import xpfec_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration write channel.
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [LEN_W-1:0]     cfg_data_i,
  // Operation stream.
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_DATA_W-1:0]  s_axis_tdata,  // [10:0] byte_offset, [18:11] data_byte
  input  logic [S_USER_W-1:0]  s_axis_tuser,  // [1:0] opcode
  // Result stream.
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_DATA_W-1:0]  m_axis_tdata,  // [7:0] parity_byte, [19:8] group_length
  output logic [M_USER_W-1:0]  m_axis_tuser   // [1:0] status, [2] offset_error
);

  localparam logic [LEN_W-1:0]   MAX_LEN   = LEN_W'(MAX_BYTES);
  localparam logic [EPOCH_W-1:0] EPOCH_TOP = {EPOCH_W{1'b1}};
  localparam logic [EPOCH_W-1:0] EPOCH_ONE = EPOCH_W'(1);
  localparam logic [ADDR_W-1:0]  ADDR_TOP  = ADDR_W'(MAX_BYTES - 1);

  // Configuration registers.
  logic             mode_q;
  logic [LEN_W-1:0] limit_q;

  // Pipeline and state registers.
  logic               s1_valid_q;
  logic [1:0]         s1_op_q;
  logic [OFF_W-1:0]   s1_off_q;
  logic [BYTE_W-1:0]  s1_data_q;
  logic               fwd_q, fwd_d;
  logic [BYTE_W-1:0]  fwd_byte_q;
  logic [EPOCH_W-1:0] epoch_q, epoch_d;
  logic               sweep_q, sweep_d;
  logic [ADDR_W-1:0]  sweep_cnt_q;
  logic [LEN_W-1:0]   length_q, length_d;
  logic [1:0]         absent_q, absent_d;
  logic               out_valid_q;
  logic [BYTE_W-1:0]  out_byte_q, out_byte_d;
  logic [LEN_W-1:0]   out_len_q;
  logic [1:0]         out_status_q, out_status_d;
  logic               out_oerr_q, out_oerr_d;

  // Operation fields.
  logic [1:0]        in_op;
  logic [OFF_W-1:0]  in_off;
  logic [BYTE_W-1:0] in_data;
  logic              in_accept;

  // Stage two signals.
  logic               s1_go, s1_free, wrap_hold;
  logic [ENTRY_W-1:0] rd_entry;
  logic [LEN_W-1:0]   eff_limit, off_plus1;
  logic               in_range, old_valid, s1_write;
  logic [BYTE_W-1:0]  old_byte, acc_byte;

  // RAM port signals.
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;

  assign in_op   = s_axis_tuser[1:0];
  assign in_off  = s_axis_tdata[OFF_W-1:0];
  assign in_data = s_axis_tdata[OFF_W+BYTE_W-1:OFF_W];

  // Configuration port is always ready.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      limit_q <= MAX_LEN;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        CFG_MODE:  mode_q  <= cfg_data_i[0];
        CFG_LIMIT: limit_q <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  // Handshake control: stage two moves when the output register frees up.
  assign s1_go     = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s1_free   = !s1_valid_q || s1_go;
  assign wrap_hold = s1_valid_q && (s1_op_q == OP_CLEAR) && (epoch_q == EPOCH_TOP);
  assign s_axis_tready = !sweep_q && s1_free && !wrap_hold;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // Stage two: decode the stored entry and form the result.
  always_comb begin
    eff_limit = (limit_q > MAX_LEN) ? MAX_LEN : limit_q;
    in_range  = {1'b0, s1_off_q} < eff_limit;
    off_plus1 = {1'b0, s1_off_q} + LEN_W'(1);
    old_valid = fwd_q || (rd_entry[ENTRY_W-1:BYTE_W] == epoch_q);
    old_byte  = fwd_q ? fwd_byte_q : rd_entry[BYTE_W-1:0];
    acc_byte  = old_valid ? (old_byte ^ s1_data_q) : s1_data_q;
    s1_write  = (s1_op_q == OP_ACCUM) && in_range;

    length_d     = length_q;
    absent_d     = absent_q;
    epoch_d      = epoch_q;
    out_byte_d   = '0;
    out_status_d = ST_OK;
    out_oerr_d   = 1'b0;

    case (s1_op_q)
      OP_CLEAR: begin
        length_d = '0;
        absent_d = '0;
        epoch_d  = (epoch_q == EPOCH_TOP) ? EPOCH_ONE : epoch_q + EPOCH_ONE;
      end
      OP_ACCUM: begin
        out_oerr_d = !in_range;
        if (in_range && (off_plus1 > length_q)) begin
          length_d = off_plus1;
        end
      end
      OP_ABSENT: begin
        if (absent_q < ABSENT_SAT) begin
          absent_d = absent_q + 2'd1;
        end
      end
      OP_READ: begin
        out_oerr_d = !in_range;
        if (mode_q && (absent_q != ABSENT_ONE)) begin
          out_status_d = ST_NOT_REC;
        end else if (length_q == '0) begin
          out_status_d = ST_EMPTY;
        end else if (in_range && ({1'b0, s1_off_q} < length_q) && old_valid) begin
          out_byte_d = old_byte;
        end
      end
      default: ;
    endcase
  end

  // Forward a byte written back this cycle to a read of the same offset.
  assign fwd_d = s1_go && s1_write && (s1_off_q == in_off);

  // Sweep starts after reset and when a clear wraps the epoch.
  assign sweep_d = (sweep_q && (sweep_cnt_q != ADDR_TOP)) ||
                   (s1_go && (s1_op_q == OP_CLEAR) && (epoch_q == EPOCH_TOP));

  // RAM write port: sweep retags to zero, otherwise stage two writes back.
  always_comb begin
    if (sweep_q) begin
      ram_we    = 1'b1;
      ram_waddr = sweep_cnt_q;
      ram_wdata = '0;
    end else begin
      ram_we    = s1_go && s1_write;
      ram_waddr = s1_off_q[ADDR_W-1:0];
      ram_wdata = {epoch_q, acc_byte};
    end
  end

  xpfec_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_accept),
    .raddr_i (in_off[ADDR_W-1:0]),
    .rdata_o (rd_entry)
  );

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_q       <= 1'b0;
      epoch_q     <= EPOCH_ONE;
      sweep_q     <= 1'b1;
      sweep_cnt_q <= '0;
      length_q    <= '0;
      absent_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      sweep_q <= sweep_d;
      if (sweep_q) begin
        sweep_cnt_q <= sweep_cnt_q + ADDR_W'(1);
      end else begin
        sweep_cnt_q <= '0;
      end
      if (s1_free) begin
        s1_valid_q <= in_accept;
      end
      if (in_accept) begin
        fwd_q <= fwd_d;
      end
      if (s1_go) begin
        epoch_q     <= epoch_d;
        length_q    <= length_d;
        absent_q    <= absent_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_op_q    <= in_op;
      s1_off_q   <= in_off;
      s1_data_q  <= in_data;
      fwd_byte_q <= acc_byte;
    end
    if (s1_go) begin
      out_byte_q   <= out_byte_d;
      out_len_q    <= length_d;
      out_status_q <= out_status_d;
      out_oerr_q   <= out_oerr_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(M_DATA_W - BYTE_W - LEN_W)'(0), out_len_q, out_byte_q};
  assign m_axis_tuser  = {out_oerr_q, out_status_q};

  // No operation is taken while the store is being retagged.
  a_no_accept_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sweep_q |-> !s_axis_tready)
    else $error("operation accepted during store sweep");

  // The epoch never takes the value used to mark swept entries.
  a_epoch_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    epoch_q != '0)
    else $error("epoch tag reached zero");

  // A stalled result keeps its payload until the receiver takes it.
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
    $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // A valid result never carries an undefined status code.
  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser[1:0] == ST_OK || m_axis_tuser[1:0] == ST_EMPTY ||
                       m_axis_tuser[1:0] == ST_NOT_REC))
    else $error("illegal status code");

  // A clear that wraps the epoch starts a sweep in the next cycle.
  a_wrap_sweeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_go && (s1_op_q == OP_CLEAR) && (epoch_q == EPOCH_TOP) |=>
    sweep_q && (epoch_q == EPOCH_ONE))
    else $error("epoch wrap did not start a sweep");

endmodule
